### hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands; they collapse to nothing under synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check that a property holds on every rising clock edge outside reset.
`define AEB_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that an expression never becomes true outside reset.
`define AEB_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define AEB_ASSERT(lbl, clk, rst_n, prop, msg)
`define AEB_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

### hdl/aeb_pkg.sv
// ---------------------------------------------------------------------------
// Amplitude envelope binner package
// Sizes, constants, shared types and helper functions.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package aeb_pkg;

	localparam int BINS        = 64;
	localparam int SAMPLE_BITS = 16;
	localparam int SAMPLE_W    = 16;
	localparam int SUM_W       = 48;
	localparam int Q_W         = 7;
	localparam int ACC_W       = SUM_W + Q_W;
	localparam int BIN_W       = $clog2(BINS);
	localparam int CUR_W       = $clog2(BINS + 1);
	localparam int STEP_W      = $clog2(Q_W);
	localparam int CNT_W       = 32;
	localparam int BIN_OUT_W   = 6;
	localparam int PCT_W       = 7;
	localparam int PADDR_W     = 2;
	localparam int PDATA_W     = 32;

	localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
	localparam logic [PCT_W-1:0]   PCT_FULL  = PCT_W'(100);
	localparam logic [PADDR_W-1:0] ADDR_SPB  = '0;
	localparam logic [CNT_W-1:0]   SPB_RESET = CNT_W'(1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_ADD,
		ST_MAX,
		ST_ORD,
		ST_MUL1,
		ST_MUL2,
		ST_DIV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [BIN_W-1:0] raddr;
		logic             we;
		logic [BIN_W-1:0] waddr;
		logic [SUM_W-1:0] wdata;
		logic             clr;
	} store_req_t;

	typedef struct packed {
		logic [ACC_W-1:0] a;
		logic [ACC_W-1:0] b;
		logic             sub;
	} alu_req_t;

	// Magnitude of the low SAMPLE_BITS bits; the most negative code maps to 2^(SAMPLE_BITS-1).
	function automatic logic [SAMPLE_BITS-1:0] abs_sample(input logic [SAMPLE_W-1:0] raw);
		logic [SAMPLE_BITS-1:0] v;
		v = raw[SAMPLE_BITS-1:0];
		return v[SAMPLE_BITS-1] ? SAMPLE_BITS'(~v + 1'b1) : v;
	endfunction

	function automatic logic [ACC_W-1:0] widen_sum(input logic [SUM_W-1:0] s);
		return {{(ACC_W - SUM_W){1'b0}}, s};
	endfunction

endpackage

### hdl/aeb_bin_store.sv
// ---------------------------------------------------------------------------
// Bin sum store
// One write and one registered read per cycle; valid bits make unwritten bins read zero.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module aeb_bin_store import aeb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  store_req_t       req,
	output logic [SUM_W-1:0] rdata
);

	logic [SUM_W-1:0] mem_q [BINS];
	logic [BINS-1:0]  valid_q;
	logic [SUM_W-1:0] rd_q;
	logic             rd_valid_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		rd_q <= mem_q[req.raddr];
	end

	// Clear all bins at once by dropping their valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (req.clr) begin
				valid_q <= '0;
			end else if (req.we) begin
				valid_q[req.waddr] <= 1'b1;
			end
			rd_valid_q <= valid_q[req.raddr];
		end
	end

	assign rdata = rd_valid_q ? rd_q : '0;

endmodule

### hdl/aeb_alu.sv
// ---------------------------------------------------------------------------
// Shared adder / subtractor
// Wide add or subtract with carry out; carry set on subtract means a >= b.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module aeb_alu import aeb_pkg::*; (
	input  alu_req_t         req,
	output logic [ACC_W:0]   res
);

	logic [ACC_W-1:0] b_eff;

	assign b_eff = req.sub ? ~req.b : req.b;
	assign res   = {1'b0, req.a} + {1'b0, b_eff} + (ACC_W + 1)'(req.sub);

endmodule

### hdl/aeb_ctrl.sv
// ---------------------------------------------------------------------------
// Envelope sequencer
// Drives the shared unit through accumulate, peak update, scale and divide steps.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module aeb_ctrl import aeb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [SAMPLE_W-1:0]  sample,
	input  logic                 last,
	input  logic [CNT_W-1:0]     spb,
	input  logic [SUM_W-1:0]     rdata,
	input  logic [ACC_W:0]       alu_res,
	output logic                 busy,
	output store_req_t           store_req,
	output alu_req_t             alu_req,
	output logic                 valid,
	output logic [BIN_OUT_W-1:0] bin,
	output logic [PCT_W-1:0]     percent,
	output logic                 last_bin
);

	state_t                 state_q, state_d;
	logic [CUR_W-1:0]       cur_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [SUM_W-1:0]       max_q;
	logic [BIN_W-1:0]       obin_q;
	logic [STEP_W-1:0]      step_q;
	logic                   last_q;
	logic                   valid_q;
	logic [SAMPLE_BITS-1:0] abs_q;
	logic [SUM_W-1:0]       sum_q;
	logic [ACC_W-1:0]       acc_q;
	logic [Q_W-1:0]         quo_q;
	logic [BIN_OUT_W-1:0]   bin_q;
	logic [PCT_W-1:0]       pct_q;
	logic                   lastb_q;

	logic [CNT_W-1:0] limit;
	logic [CNT_W:0]   cnt_inc;
	logic             bin_full;
	logic [SUM_W-1:0] sum_new;
	logic             obin_last;
	logic             room;

	assign limit     = (spb == '0) ? CNT_W'(1) : spb;
	assign cnt_inc   = {1'b0, cnt_q} + (CNT_W + 1)'(1);
	assign bin_full  = cnt_inc >= {1'b0, limit};
	assign sum_new   = (alu_res[ACC_W:SUM_W] != '0) ? SUM_MAX : alu_res[SUM_W-1:0];
	assign obin_last = obin_q == BIN_W'(BINS - 1);
	assign room      = cur_q < CUR_W'(BINS);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (room) begin
						state_d = ST_RD;
					end else if (last) begin
						state_d = ST_ORD;
					end
				end
			end
			ST_RD:   state_d = ST_ADD;
			ST_ADD:  state_d = ST_MAX;
			ST_MAX:  state_d = last_q ? ST_ORD : ST_IDLE;
			ST_ORD:  state_d = ST_MUL1;
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_DIV;
			ST_DIV:  state_d = (step_q == '0) ? ST_EMIT : ST_DIV;
			ST_EMIT: state_d = obin_last ? ST_IDLE : ST_ORD;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		alu_req         = '0;
		store_req       = '0;
		store_req.raddr = cur_q[BIN_W-1:0];
		busy            = state_q != ST_IDLE;
		unique case (state_q)
			ST_ADD: begin
				alu_req.a       = widen_sum(rdata);
				alu_req.b       = ACC_W'(abs_q);
				store_req.we    = 1'b1;
				store_req.waddr = cur_q[BIN_W-1:0];
				store_req.wdata = sum_new;
			end
			ST_MAX: begin
				alu_req.a   = widen_sum(max_q);
				alu_req.b   = widen_sum(sum_q);
				alu_req.sub = 1'b1;
			end
			ST_ORD: begin
				store_req.raddr = obin_q;
			end
			ST_MUL1: begin
				// sum * 96
				alu_req.a = widen_sum(rdata) << 6;
				alu_req.b = widen_sum(rdata) << 5;
			end
			ST_MUL2: begin
				// plus sum * 4
				alu_req.a = acc_q;
				alu_req.b = widen_sum(sum_q) << 2;
			end
			ST_DIV: begin
				alu_req.a   = acc_q;
				alu_req.b   = widen_sum(max_q) << step_q;
				alu_req.sub = 1'b1;
			end
			ST_EMIT: begin
				store_req.clr = obin_last;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cur_q   <= '0;
			cnt_q   <= '0;
			max_q   <= '0;
			obin_q  <= '0;
			step_q  <= '0;
			last_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						last_q <= last;
					end
				end
				ST_MAX: begin
					if (!alu_res[ACC_W]) begin
						max_q <= sum_q;
					end
					if (bin_full) begin
						cnt_q <= '0;
						cur_q <= cur_q + CUR_W'(1);
					end else begin
						cnt_q <= cnt_inc[CNT_W-1:0];
					end
				end
				ST_MUL2: step_q <= STEP_W'(Q_W - 1);
				ST_DIV:  step_q <= step_q - STEP_W'(1);
				ST_EMIT: begin
					valid_q <= 1'b1;
					if (obin_last) begin
						obin_q <= '0;
						cur_q  <= '0;
						cnt_q  <= '0;
						max_q  <= '0;
						last_q <= 1'b0;
					end else begin
						obin_q <= obin_q + BIN_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					abs_q <= abs_sample(sample);
				end
			end
			ST_ADD:  sum_q <= sum_new;
			ST_MUL1: begin
				sum_q <= rdata;
				acc_q <= alu_res[ACC_W-1:0];
			end
			ST_MUL2: begin
				acc_q <= alu_res[ACC_W-1:0];
				quo_q <= '0;
			end
			ST_DIV: begin
				if (alu_res[ACC_W]) begin
					acc_q <= alu_res[ACC_W-1:0];
				end
				quo_q <= {quo_q[Q_W-2:0], alu_res[ACC_W]};
			end
			ST_EMIT: begin
				bin_q   <= BIN_OUT_W'(obin_q);
				pct_q   <= (max_q == '0) ? '0 : PCT_W'(quo_q);
				lastb_q <= obin_last;
			end
			default: begin
			end
		endcase
	end

	assign valid    = valid_q;
	assign bin      = bin_q;
	assign percent  = pct_q;
	assign last_bin = lastb_q;

endmodule

### hdl/amplitude_envelope_binner.sv
// ---------------------------------------------------------------------------
// Amplitude envelope binner
// Sums sample magnitudes into bins and reports each bin relative to the peak bin.
// ---------------------------------------------------------------------------
//
//   Channel   Handshake                     Payload
//   -------   ---------------------------   ------------------------
//   config    psel & penable & pwrite       paddr, pwdata (prdata)
//   sample    start & !busy                 sample, last
//   result    valid (one-cycle strobe)      bin, percent, last_bin
//
// An accepted sample holds busy through the read, add and peak-update states, and
// no new beat is taken until it is idle again; a sample arriving once every bin is
// full is dropped without raising busy. A beat with last set then runs the report
// burst, per bin a read, two scale steps, seven divide steps and an emit, all
// through the one shared adder, with the results strobed one per bin in bin order.
// Reset is asynchronous and clears the bin store at once through its valid bits;
// no clearing pass. The receiver cannot stall the result strobe.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module amplitude_envelope_binner import aeb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [PDATA_W-1:0]   pwdata,
	output logic [PDATA_W-1:0]   prdata,
	output logic                 pready,
	// sample command
	input  logic                 start,
	output logic                 busy,
	input  logic [SAMPLE_W-1:0]  sample,
	input  logic                 last,
	// result strobe
	output logic                 valid,
	output logic [BIN_OUT_W-1:0] bin,
	output logic [PCT_W-1:0]     percent,
	output logic                 last_bin
);

	logic [CNT_W-1:0] spb_q;
	store_req_t       store_req;
	alu_req_t         alu_req;
	logic [SUM_W-1:0] rdata;
	logic [ACC_W:0]   alu_res;

	// Register file: samples per bin only. Zero is read back as written and
	// treated as one by the sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spb_q <= SPB_RESET;
		end else if (psel && penable && pwrite && pready && paddr == ADDR_SPB) begin
			spb_q <= pwdata;
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_SPB) ? spb_q : '0;

	// Sequencer: owns bin position, peak and the per-bin divide
	aeb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.sample   (sample),
		.last     (last),
		.spb      (spb_q),
		.rdata    (rdata),
		.alu_res  (alu_res),
		.busy     (busy),
		.store_req(store_req),
		.alu_req  (alu_req),
		.valid    (valid),
		.bin      (bin),
		.percent  (percent),
		.last_bin (last_bin)
	);

	// Bin sums, one read and one write a cycle
	aeb_bin_store u_store (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (store_req),
		.rdata (rdata)
	);

	// The one adder shared by accumulate, compare, scale and divide
	aeb_alu u_alu (
		.req(alu_req),
		.res(alu_res)
	);

	// A result strobe only ever follows a busy cycle
	`AEB_ASSERT(a_valid_after_busy, clk, arst_n, valid |-> $past(busy), "result without burst")
	// Percent never exceeds full scale
	`AEB_ASSERT(a_pct_range, clk, arst_n, valid |-> percent <= PCT_FULL, "percent above full scale")
	// Final-bin mark only on the highest bin
	`AEB_NEVER(a_last_bin_idx, clk, arst_n, valid && last_bin && bin != BIN_OUT_W'(BINS - 1), "last_bin on wrong bin")
	// More bins follow a non-final result, so the burst keeps running
	`AEB_ASSERT(a_burst_runs, clk, arst_n, valid && !last_bin |=> busy, "burst stopped early")

endmodule

### verif/amplitude_envelope_binner_test.sv
// ---------------------------------------------------------------------------
// Amplitude envelope binner testbench
// Drives recordings of signed samples through the command port, sets the
// bin length over the register port, and checks every bin report against an
// in-bench model of the binning and peak-normalisation arithmetic.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module amplitude_envelope_binner_test;
	import aeb_pkg::*;

	localparam int SETTLE_CYCLES = 24;      // idle tail after the last report beat
	localparam int CYCLE_LIMIT   = 400000;  // far beyond the slowest legal run
	localparam int PRINT_CAP     = 40;      // keep a broken build from flooding the log

	typedef struct {
		logic [BIN_OUT_W-1:0] bin;
		logic [PCT_W-1:0]     percent;
		logic                 last_bin;
	} bin_report_t;

	// Block ports; every input has a known value from time zero.
	logic                 clk     = 1'b0;
	logic                 arst_n  = 1'b0;
	logic                 psel    = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite  = 1'b0;
	logic [PADDR_W-1:0]   paddr   = '0;
	logic [PDATA_W-1:0]   pwdata  = '0;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;
	logic                 start   = 1'b0;
	logic                 busy;
	logic [SAMPLE_W-1:0]  sample  = '0;
	logic                 last    = 1'b0;
	logic                 valid;
	logic [BIN_OUT_W-1:0] bin;
	logic [PCT_W-1:0]     percent;
	logic                 last_bin;

	// Envelope model state, predicted in the bench apart from the block's own state.
	logic [CNT_W-1:0]   spb_shadow = SPB_RESET;
	logic [SUM_W-1:0]   bin_total [BINS] = '{default: '0};
	logic [CUR_W-1:0]   fill_bin   = '0;
	logic [CNT_W-1:0]   fill_count = '0;
	logic [SUM_W-1:0]   peak_total = '0;

	bin_report_t pending_reports [$];
	bin_report_t head_report;

	int unsigned sender_idle_pct = 0;
	int unsigned mismatches      = 0;
	int unsigned items_sent      = 0;
	int unsigned results_checked = 0;
	int unsigned recordings      = 0;
	int unsigned config_writes   = 0;
	int unsigned cycle_count     = 0;

	amplitude_envelope_binner dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.start    (start),
		.busy     (busy),
		.sample   (sample),
		.last     (last),
		.valid    (valid),
		.bin      (bin),
		.percent  (percent),
		.last_bin (last_bin)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Watchdog: a hung handshake or a missing report beat ends up here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("ERROR: watchdog expired after %0d cycles, %0d reports outstanding",
				cycle_count, pending_reports.size());
			$display("amplitude_envelope_binner verification failed");
			$finish;
		end
	end

	// Print one line per problem (up to a cap) and count every one.
	task automatic flag_error(input string msg);
		if (mismatches < PRINT_CAP)
			$display("ERROR @%0t: %s", $realtime, msg);
		mismatches++;
	endtask

	// Advance the envelope model by one accepted sample beat. Accumulate the
	// magnitude into the bin being filled, drop it once every bin is full, and
	// on a last beat queue one report per bin, then clear for the next recording.
	task automatic envelope_predict(input logic [SAMPLE_W-1:0] raw, input logic is_last);
		logic [CNT_W-1:0]       bin_len;
		logic [SAMPLE_BITS-1:0] mag;
		logic [SUM_W:0]         total;
		logic [63:0]            scaled;
		bin_report_t            rep;
		bin_len = (spb_shadow == '0) ? CNT_W'(1) : spb_shadow;
		if (fill_bin < BINS) begin
			// The most negative code wraps back onto itself, which read unsigned
			// is exactly its magnitude.
			mag   = raw[SAMPLE_BITS-1] ? SAMPLE_BITS'(-$signed(raw[SAMPLE_BITS-1:0]))
				: raw[SAMPLE_BITS-1:0];
			total = {1'b0, bin_total[fill_bin]} + (SUM_W + 1)'(mag);
			if (total > {1'b0, SUM_MAX})
				total = {1'b0, SUM_MAX};
			bin_total[fill_bin] = total[SUM_W-1:0];
			if (total[SUM_W-1:0] > peak_total)
				peak_total = total[SUM_W-1:0];
			fill_count++;
			if (fill_count >= bin_len) begin
				fill_count = '0;
				fill_bin++;
			end
		end
		if (is_last) begin
			for (int k = 0; k < BINS; k++) begin
				scaled = '0;
				if (peak_total != '0)
					scaled = (64'(bin_total[k]) * 64'd100) / 64'(peak_total);
				rep.bin      = BIN_OUT_W'(k);
				rep.percent  = PCT_W'(scaled);
				rep.last_bin = (k == BINS - 1);
				pending_reports.push_back(rep);
			end
			for (int k = 0; k < BINS; k++)
				bin_total[k] = '0;
			fill_bin   = '0;
			fill_count = '0;
			peak_total = '0;
		end
	endtask

	// Present one sample beat, idling first at the current rate. start stays
	// high after acceptance so back-to-back beats need no extra assignment.
	task automatic send_beat(input logic [SAMPLE_W-1:0] value, input logic is_last);
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start  <= 1'b1;
		sample <= value;
		last   <= is_last;
		do @(posedge clk); while (busy);
		envelope_predict(value, is_last);
		items_sent++;
	endtask

	// Drop start and hold off until every queued report has arrived, then let
	// the block settle back to idle.
	task automatic drain_results;
		start <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Two-phase register write: setup, then access until pready.
	task automatic write_spb(input logic [PDATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_SPB;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		spb_shadow = value;
		config_writes++;
	endtask

	// Read the bin length back and compare with the shadow copy.
	task automatic check_spb_readback;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_SPB;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== spb_shadow)
			flag_error($sformatf("samples_per_bin readback: expected %0h got %0h",
				spb_shadow, prdata));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Change the bin length only with the block drained and idle; leave the
	// bus idle between the write and the read-back.
	task automatic apply_spb(input logic [PDATA_W-1:0] value);
		drain_results;
		write_spb(value);
		@(posedge clk);
		check_spb_readback;
	endtask

	// Mostly full-range noise, with a share of rail values, silence and
	// near-zero values of either sign.
	function automatic logic [SAMPLE_W-1:0] pick_sample;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 60)
			return SAMPLE_W'($urandom);
		if (pick < 70)
			return $urandom_range(1) ? 16'h7FFF : 16'h8000;
		if (pick < 80)
			return '0;
		return $urandom_range(1) ? SAMPLE_W'($urandom_range(15))
			: SAMPLE_W'(-$signed(SAMPLE_W'($urandom_range(15))));
	endfunction

	// Check each report beat against the oldest queued expectation.
	always @(posedge clk) begin
		if (arst_n && valid) begin
			if (pending_reports.size() == 0) begin
				flag_error($sformatf("report beat for bin %0d with nothing pending", bin));
			end else begin
				head_report = pending_reports.pop_front();
				if (bin !== head_report.bin)
					flag_error($sformatf("bin: expected %0d got %0d", head_report.bin, bin));
				if (percent !== head_report.percent)
					flag_error($sformatf("percent of bin %0d: expected %0d got %0d",
						head_report.bin, head_report.percent, percent));
				if (last_bin !== head_report.last_bin)
					flag_error($sformatf("last_bin of bin %0d: expected %0b got %0b",
						head_report.bin, head_report.last_bin, last_bin));
				results_checked++;
			end
		end
	end

	// Register must come out of reset at one sample per bin.
	task automatic test_register_reset;
		check_spb_readback;
	endtask

	// Silence only: the peak is zero, so every bin reports zero.
	task automatic test_silent_recording;
		send_beat(16'h0000, 1'b0);
		send_beat(16'h0000, 1'b1);
		recordings++;
	endtask

	// One sample per bin, walking the rails, both near-zero codes and
	// alternating bit patterns; the most negative code sets the peak.
	task automatic test_sample_extremes;
		logic [SAMPLE_W-1:0] walk [9];
		walk = '{16'h7FFF, 16'h8000, 16'h8001, 16'h0001, 16'hFFFF,
			16'h0000, 16'h5555, 16'hAAAA, 16'h0064};
		apply_spb(32'd1);
		for (int i = 0; i < 9; i++)
			send_beat(walk[i], i == 8);
		recordings++;
	endtask

	// A bin length of zero must behave as one.
	task automatic test_zero_spb;
		apply_spb(32'd0);
		for (int i = 0; i < 8; i++)
			send_beat(pick_sample(), i == 7);
		recordings++;
	endtask

	// Longest bin length: everything lands in bin zero.
	task automatic test_max_spb;
		apply_spb(32'hFFFF_FFFF);
		for (int i = 0; i < 4; i++)
			send_beat(pick_sample(), i == 3);
		recordings++;
	endtask

	// Whole recordings with random content. Reconfigure now and then (which
	// drains the block first); otherwise let the next recording queue up
	// behind the report burst. Only lengths of 0 or 1 can overrun the last bin.
	task automatic test_random_recordings(input int unsigned idle_pct,
		input int unsigned item_budget);
		int unsigned used;
		int unsigned len;
		int unsigned pick;
		logic [PDATA_W-1:0] spb_val;
		sender_idle_pct = idle_pct;
		used = 0;
		while (used < item_budget) begin
			if ($urandom_range(1) == 0) begin
				pick = $urandom_range(9);
				if (pick < 4)
					spb_val = 32'd1;
				else if (pick < 5)
					spb_val = 32'd0;
				else if (pick < 8)
					spb_val = PDATA_W'($urandom_range(5, 2));
				else if (pick < 9)
					spb_val = PDATA_W'($urandom);
				else
					spb_val = PDATA_W'($urandom_range(20, 6));
				apply_spb(spb_val);
			end
			if (spb_shadow <= 32'd1 && $urandom_range(3) == 0)
				len = $urandom_range(80, 65);
			else
				len = $urandom_range(30, 1);
			for (int i = 0; i < len; i++)
				send_beat(pick_sample(), i == len - 1);
			used += len;
			recordings++;
		end
	endtask

	initial begin
		// Hold reset, then release it once.
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		sender_idle_pct = 21;
		test_register_reset;
		test_silent_recording;
		test_sample_extremes;
		test_zero_spb;
		test_max_spb;

		test_random_recordings(21, 50);
		test_random_recordings(57, 50);
		test_random_recordings(0, 50);

		drain_results;
		if (pending_reports.size() != 0)
			flag_error($sformatf("%0d reports never arrived", pending_reports.size()));

		$display("Sent %0d sample beats in %0d recordings across %0d bin length settings.",
			items_sent, recordings, config_writes);
		$display("Checked %0d bin reports; %0d problems found.", results_checked, mismatches);
		if (mismatches == 0) begin
			$display("amplitude_envelope_binner verification clean");
		end else begin
			$display("amplitude_envelope_binner verification failed");
		end
		$finish;
	end

endmodule

### sim.f
+incdir+hdl
hdl/aeb_pkg.sv
hdl/aeb_bin_store.sv
hdl/aeb_alu.sv
hdl/aeb_ctrl.sv
hdl/amplitude_envelope_binner.sv
verif/amplitude_envelope_binner_test.sv
